// File: hw/rtl/efr_pkg.sv
package efr_pkg;

   // frame size limit in decoded bytes after the type byte, checksum included
   localparam int MaxMessage = 64;
   localparam int CountWidth = $clog2(MaxMessage + 1);

   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 24;

   localparam logic [7:0] ResetEndCode           = 8'd192;
   localparam logic [7:0] ResetEscapeCode        = 8'd219;
   localparam logic [7:0] ResetEscapedEndCode    = 8'd220;
   localparam logic [7:0] ResetEscapedEscapeCode = 8'd221;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_CSUM    = 2'd2,
      KIND_LONG    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_END_CODE       = 2'd0,
      REG_ESCAPE_CODE    = 2'd1,
      REG_ESCAPED_END    = 2'd2,
      REG_ESCAPED_ESCAPE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [7:0] end_code;
      logic [7:0] escape_code;
      logic [7:0] escaped_end_code;
      logic [7:0] escaped_escape_code;
   } codes_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [7:0] frame_type;
      logic [5:0] payload_length;
   } result_type;

endpackage

// File: hw/rtl/efr_frame_decoder.sv
module efr_frame_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          line_byte,
   input  efr_pkg::codes_type  codes,
   output logic                result_valid,
   output efr_pkg::result_type result
);
   import efr_pkg::*;

   logic                  escape_pending_ff, escape_pending_in;
   logic                  type_seen_ff, type_seen_in;
   logic [7:0]            type_value_ff, type_value_in;
   logic [7:0]            running_sum_ff, running_sum_in;
   logic [CountWidth-1:0] byte_count_ff, byte_count_in;
   logic [7:0]            held_byte_ff, held_byte_in;
   logic                  discarding_ff, discarding_in;
   logic [7:0]            decoded;

   always_comb begin
      decoded = line_byte;
      if (escape_pending_ff) begin
         if (line_byte == codes.escaped_escape_code) begin
            decoded = codes.escape_code;
         end else if (line_byte == codes.escaped_end_code) begin
            decoded = codes.end_code;
         end
      end
   end

   always_comb begin
      escape_pending_in = escape_pending_ff;
      type_seen_in      = type_seen_ff;
      type_value_in     = type_value_ff;
      running_sum_in    = running_sum_ff;
      byte_count_in     = byte_count_ff;
      held_byte_in      = held_byte_ff;
      discarding_in     = discarding_ff;
      result_valid      = 1'b0;
      result            = '0;
      if (step) begin
         if (discarding_ff) begin
            // drop raw bytes until the next end code
            if (line_byte == codes.end_code) begin
               escape_pending_in = 1'b0;
               type_seen_in      = 1'b0;
               running_sum_in    = '0;
               byte_count_in     = '0;
               discarding_in     = 1'b0;
            end
         end else if (line_byte == codes.escape_code) begin
            escape_pending_in = 1'b1;
         end else if (line_byte == codes.end_code) begin
            escape_pending_in = 1'b0;
            type_seen_in      = 1'b0;
            running_sum_in    = '0;
            byte_count_in     = '0;
            // no report without a type byte and a checksum byte
            if (type_seen_ff && (byte_count_ff != '0)) begin
               result_valid = 1'b1;
               if (running_sum_ff != 8'd0) begin
                  result.kind = KIND_CSUM;
               end else begin
                  result.kind           = KIND_GOOD;
                  result.frame_type     = type_value_ff;
                  result.payload_length = 6'(byte_count_ff - CountWidth'(1));
               end
            end
         end else begin
            escape_pending_in = 1'b0;
            running_sum_in    = running_sum_ff + decoded;
            if (!type_seen_ff) begin
               type_seen_in  = 1'b1;
               type_value_in = decoded;
            end else if (byte_count_ff >= CountWidth'(MaxMessage)) begin
               type_seen_in   = 1'b0;
               running_sum_in = '0;
               byte_count_in  = '0;
               discarding_in  = 1'b1;
               result_valid   = 1'b1;
               result.kind    = KIND_LONG;
            end else begin
               byte_count_in = byte_count_ff + CountWidth'(1);
               held_byte_in  = decoded;
               // the held byte goes out once the next byte shows it was not the checksum
               if (byte_count_ff != '0) begin
                  result_valid        = 1'b1;
                  result.kind         = KIND_PAYLOAD;
                  result.payload_byte = held_byte_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
         type_seen_ff      <= 1'b0;
         running_sum_ff    <= '0;
         byte_count_ff     <= '0;
         discarding_ff     <= 1'b0;
      end else begin
         escape_pending_ff <= escape_pending_in;
         type_seen_ff      <= type_seen_in;
         running_sum_ff    <= running_sum_in;
         byte_count_ff     <= byte_count_in;
         discarding_ff     <= discarding_in;
      end
   end

   always_ff @(posedge clock) begin
      type_value_ff <= type_value_in;
      held_byte_ff  <= held_byte_in;
   end

endmodule

// File: hw/rtl/escaped_frame_receiver.sv
// escaped_frame_receiver: strips escape-coded framing from a byte stream.
// req_ channel: one raw line byte per transaction in req_tdata[7:0].
// rsp_ channel: zero or one result per line byte; rsp_tuser gives the kind
//   (payload byte, frame good, checksum error, frame too long) and rsp_tdata
//   carries payload byte, frame type and payload length.
// csr_ channel: register writes (end code, escape code, escaped end code, escaped escape code);
//   always ready; the user must write only while the block is idle, the block does not enforce it.
// A byte accepted goes into the input register and is decoded into the result
//   register when the result register is free or being emptied.
// Throughput: one byte per cycle while results are taken, set by the single
//   decode step between the input register and the result register; a line
//   byte with no result still passes through that step.
// When the receiver stalls, the result register holds, the input register keeps its byte
//   or takes one if it was empty, and req_tready stays low until a result is taken.
// Reset clears the frame state, restores the default codes and empties both
//   registers; there is no clearing pass.
module escaped_frame_receiver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [efr_pkg::ReqDataWidth-1:0] req_tdata,   // line_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // payload_byte [7:0], frame_type [15:8], payload_length [21:16], zero [23:22]
   output logic [efr_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic [1:0]                       rsp_tuser,   // result_kind
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  efr_pkg::reg_index_type           csr_index,
   input  logic [7:0]                       csr_data
);
   import efr_pkg::*;

   codes_type  codes_ff, codes_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff, rsp_result_in;
   logic       advance;
   logic       dec_valid;
   result_type dec_result;

   assign csr_ready = 1'b1;

   always_comb begin
      codes_in = codes_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_END_CODE:       codes_in.end_code            = csr_data;
            REG_ESCAPE_CODE:    codes_in.escape_code         = csr_data;
            REG_ESCAPED_END:    codes_in.escaped_end_code    = csr_data;
            REG_ESCAPED_ESCAPE: codes_in.escaped_escape_code = csr_data;
            default:            codes_in                     = codes_ff;
         endcase
      end
   end

   // the decode step fires when the input register holds a byte and the result register is free or being emptied
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata[7:0];
      end
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (advance) begin
         rsp_valid_in = dec_valid;
         if (dec_valid) begin
            rsp_result_in = dec_result;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   efr_frame_decoder u_decoder (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .line_byte    (in_byte_ff),
      .codes        (codes_ff),
      .result_valid (dec_valid),
      .result       (dec_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.end_code            <= ResetEndCode;
         codes_ff.escape_code         <= ResetEscapeCode;
         codes_ff.escaped_end_code    <= ResetEscapedEndCode;
         codes_ff.escaped_escape_code <= ResetEscapedEscapeCode;
         in_valid_ff                  <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         codes_ff     <= codes_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.kind;
   assign rsp_tdata  = {2'b00, rsp_result_ff.payload_length,
                        rsp_result_ff.frame_type, rsp_result_ff.payload_byte};

endmodule

// File: hw/rtl/efr_checker.sv
module efr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [efr_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser
);
   import efr_pkg::*;

   // a reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or dropped");

   // only a payload result carries a payload byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_PAYLOAD) |-> rsp_tdata[7:0] == 8'd0)
      else $error("payload byte on a frame report");

   // type and length are shown on a good frame alone
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_GOOD) |-> rsp_tdata[23:8] == 16'd0)
      else $error("frame fields on a result that is not frame good");

   // the input side is open whenever the result register can move
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while the result register was free");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (.*);
